### rtl/core/pnl_running_statistics_assert.svh
// Assertion macros for the checker file of the running statistics block.
`ifndef PNL_RUNNING_STATISTICS_ASSERT_SVH
`define PNL_RUNNING_STATISTICS_ASSERT_SVH

// Same-cycle implication, off during reset.
`define PNL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pnl_running_statistics: check failed");

// Next-cycle implication, off during reset.
`define PNL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pnl_running_statistics: check failed");

`endif

### rtl/core/pnl_rs_pkg.sv
// Package: widths, constants and shared types of the running statistics block.
package pnl_rs_pkg;

  localparam int MAX_DAYS = 4096;
  localparam int PNL_BITS = 26;
  localparam int CNT_W    = 13;
  localparam int SUM_W    = 38;
  localparam int SQ_W     = 63;
  localparam int DD_W     = 20;
  localparam int WR_W     = 17;
  localparam int SH_W     = 24;
  localparam int PPY_W    = 9;

  localparam int MUL_A_W  = 75;
  localparam int MUL_B_W  = 13;
  localparam int PROD_W   = 88;
  localparam int ACC_W    = 96;
  localparam int DEN_W    = 88;
  localparam int KP_W     = 22;
  localparam int REM_W    = 89;
  localparam int QB_W     = 46;
  localparam int ROOT_W   = 23;
  localparam int STEP_W   = 6;

  localparam int DD_STEPS = 20;
  localparam int WR_STEPS = 17;
  localparam int SH_STEPS = 46;
  localparam int SQ_STEPS = 23;

  localparam logic [PPY_W-1:0] PPY_RESET  = 9'd252;
  localparam logic [DD_W-1:0]  DD_SAT     = 20'hFFFFF;
  localparam logic [SH_W-1:0]  SH_POS_SAT = 24'h7FFFFF;
  localparam logic [SH_W-1:0]  SH_NEG_SAT = 24'h800000;

  typedef enum logic [1:0] {
    CHUNK_LO  = 2'd0,
    CHUNK_MID = 2'd1,
    CHUNK_HI  = 2'd2
  } chunk_t;

  typedef struct packed {
    logic               clr;
    chunk_t             sel;
    logic [ACC_W-1:0]   acc;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mac_req_t;

  typedef struct packed {
    logic             pair;
    logic [1:0]       bits;
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] trial;
  } step_req_t;

  typedef struct packed {
    logic             ge;
    logic [REM_W-1:0] rem;
  } step_rsp_t;

endpackage

### rtl/core/pnl_rs_if.sv
// Interfaces: input item channel, result channel and configuration write channel.
interface pnl_rs_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [pnl_rs_pkg::PNL_BITS-1:0]    day_value;
  modport source (output valid, day_value, input ready);
  modport sink   (input valid, day_value, output ready);
endinterface

interface pnl_rs_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [pnl_rs_pkg::CNT_W-1:0]           day_count;
  logic signed [pnl_rs_pkg::SUM_W-1:0]    pnl_sum;
  logic signed [pnl_rs_pkg::PNL_BITS-1:0] best_day;
  logic signed [pnl_rs_pkg::PNL_BITS-1:0] worst_day;
  logic [pnl_rs_pkg::WR_W-1:0]            win_frac;
  logic [pnl_rs_pkg::DD_W-1:0]            dd_max;
  logic signed [pnl_rs_pkg::SH_W-1:0]     sharpe;
  logic                                   full_res;
  modport source (output valid, day_count, pnl_sum, best_day, worst_day, win_frac,
                  dd_max, sharpe, full_res, input ready);
  modport sink   (input valid, day_count, pnl_sum, best_day, worst_day, win_frac,
                  dd_max, sharpe, full_res, output ready);
endinterface

interface pnl_rs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pnl_rs_pkg::PPY_W-1:0]    data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/core/pnl_rs_mac.sv
// Shared multiply-accumulate unit: wide operand times a 13-bit chunk, shifted and added.
module pnl_rs_mac (
  input  pnl_rs_pkg::mac_req_t              req,
  output logic [pnl_rs_pkg::ACC_W-1:0]      sum
);
  localparam int ACC_W  = pnl_rs_pkg::ACC_W;
  localparam int PROD_W = pnl_rs_pkg::PROD_W;
  localparam int B_W    = pnl_rs_pkg::MUL_B_W;

  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  addend;
  logic [ACC_W-1:0]  base;

  assign prod = PROD_W'(req.a) * PROD_W'(req.b);

  always_comb begin
    case (req.sel)
      pnl_rs_pkg::CHUNK_LO:  addend = ACC_W'(prod);
      pnl_rs_pkg::CHUNK_MID: addend = ACC_W'(prod) << B_W;
      pnl_rs_pkg::CHUNK_HI:  addend = ACC_W'(prod) << (2 * B_W);
      default:               addend = '0;
    endcase
  end

  assign base = req.clr ? '0 : req.acc;
  assign sum  = base + addend;

endmodule

### rtl/core/pnl_rs_step.sv
// Shared shift, compare and subtract step for restoring division and square root.
module pnl_rs_step (
  input  pnl_rs_pkg::step_req_t req,
  output pnl_rs_pkg::step_rsp_t rsp
);
  localparam int REM_W = pnl_rs_pkg::REM_W;

  logic [REM_W-1:0] sh;

  always_comb begin
    // a square root step takes two new bits, a division step one
    if (req.pair) begin
      sh = {req.rem[REM_W-3:0], req.bits};
    end else begin
      sh = {req.rem[REM_W-2:0], req.bits[1]};
    end
    rsp.ge  = (sh >= req.trial);
    rsp.rem = rsp.ge ? (sh - req.trial) : sh;
  end

endmodule

### rtl/core/pnl_running_statistics.sv
// Top level: running P&L statistics with a sequencer over a shared MAC and division step.
//
//   channel  | dir | handshake       | payload
//   ---------+-----+-----------------+-------------------------------------------
//   pnl_in   | in  | valid / ready   | day_value
//   res      | out | valid / ready   | day_count .. sharpe, full_res
//   cfg      | in  | valid / ready   | periods_per_year (always ready)
//
// An item runs from accept to result through at most 20 drawdown, 17 win rate,
// 46 Sharpe quotient and 23 square root steps on the one-bit-a-cycle step unit,
// plus the MAC and control states; the input is ready again in the cycle after
// the result register is loaded. A non-positive or saturated drawdown, fewer than two days, zero
// variance or a saturated ratio skip the matching steps.
// Reset clears all statistics and loads periods_per_year with 252.
// A waiting result does not block the next accept; a finished item holds
// in its last state until the result register is free.
module pnl_running_statistics (
  input  logic                clk,
  input  logic                rst,
  pnl_rs_in_if.sink           pnl_in,
  pnl_rs_out_if.source        res,
  pnl_rs_cfg_if.sink          cfg
);
  localparam int CNT_W   = pnl_rs_pkg::CNT_W;
  localparam int SUM_W   = pnl_rs_pkg::SUM_W;
  localparam int SQ_W    = pnl_rs_pkg::SQ_W;
  localparam int DD_W    = pnl_rs_pkg::DD_W;
  localparam int WR_W    = pnl_rs_pkg::WR_W;
  localparam int SH_W    = pnl_rs_pkg::SH_W;
  localparam int PPY_W   = pnl_rs_pkg::PPY_W;
  localparam int PB      = pnl_rs_pkg::PNL_BITS;
  localparam int A_W     = pnl_rs_pkg::MUL_A_W;
  localparam int B_W     = pnl_rs_pkg::MUL_B_W;
  localparam int ACC_W   = pnl_rs_pkg::ACC_W;
  localparam int DEN_W   = pnl_rs_pkg::DEN_W;
  localparam int KP_W    = pnl_rs_pkg::KP_W;
  localparam int REM_W   = pnl_rs_pkg::REM_W;
  localparam int QB_W    = pnl_rs_pkg::QB_W;
  localparam int ROOT_W  = pnl_rs_pkg::ROOT_W;
  localparam int STEP_W  = pnl_rs_pkg::STEP_W;
  localparam int TOP_W   = ACC_W - 14;

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_SQ0   = 20'h00002,
    S_SQ1   = 20'h00004,
    S_UPD   = 20'h00008,
    S_DDS   = 20'h00010,
    S_DDDIV = 20'h00020,
    S_WRS   = 20'h00040,
    S_WRDIV = 20'h00080,
    S_M0    = 20'h00100,
    S_M1    = 20'h00200,
    S_M2    = 20'h00400,
    S_M3    = 20'h00800,
    S_M4    = 20'h01000,
    S_M5    = 20'h02000,
    S_M6    = 20'h04000,
    S_M7    = 20'h08000,
    S_M8    = 20'h10000,
    S_SHDIV = 20'h20000,
    S_SQRT  = 20'h40000,
    S_DONE  = 20'h80000
  } state_t;

  state_t state;

  // statistics
  logic [PPY_W-1:0]        ppy;
  logic [CNT_W-1:0]        days;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sumsq;
  logic signed [SUM_W-1:0] peak;
  logic [DD_W-1:0]         worst_dd;
  logic [CNT_W-1:0]        wins;
  logic signed [PB-1:0]    best;
  logic signed [PB-1:0]    worst;

  // per-item work registers
  logic signed [PB-1:0]    v;
  logic                    full;
  logic [ACC_W-1:0]        acc;
  logic [A_W-1:0]          s2;
  logic [DEN_W-1:0]        den;
  logic [DEN_W-1:0]        dvs;
  logic [KP_W-1:0]         kp;
  logic [REM_W-1:0]        r;
  logic [QB_W-1:0]         quo;
  logic [QB_W-1:0]         nbits;
  logic [ROOT_W-1:0]       root;
  logic [STEP_W-1:0]       cnt;
  logic [WR_W-1:0]         winr;
  logic signed [SH_W-1:0]  sharpe;

  // result register
  logic                    res_valid;
  logic [CNT_W-1:0]        o_days;
  logic signed [SUM_W-1:0] o_sum;
  logic signed [PB-1:0]    o_best;
  logic signed [PB-1:0]    o_worst;
  logic [WR_W-1:0]         o_winr;
  logic [DD_W-1:0]         o_dd;
  logic signed [SH_W-1:0]  o_sharpe;
  logic                    o_full;

  pnl_rs_pkg::mac_req_t    mreq;
  logic [ACC_W-1:0]        macc;
  pnl_rs_pkg::step_req_t   sreq;
  pnl_rs_pkg::step_rsp_t   srsp;

  logic [PB-1:0]           mag;
  logic [SUM_W-1:0]        abs_sum;
  logic signed [SUM_W-1:0] sum_new;
  logic [SUM_W-1:0]        diff;
  logic [A_W-1:0]          var_n;
  logic [DD_W-1:0]         dd_q;
  logic [ROOT_W-1:0]       root_q;
  logic [TOP_W-1:0]        top;
  logic                    last;
  logic                    in_acc;

  assign in_acc  = pnl_in.valid && pnl_in.ready;
  assign mag     = v[PB-1] ? PB'(-v) : PB'(v);
  assign abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign sum_new = sum + SUM_W'(v);
  assign diff    = SUM_W'(peak - sum);
  assign var_n   = acc[A_W-1:0] - s2;
  assign top     = acc[ACC_W-1:14];
  assign last    = (cnt == STEP_W'(1));
  assign dd_q    = {quo[DD_W-2:0], srsp.ge};
  assign root_q  = {root[ROOT_W-2:0], srsp.ge};

  always_comb begin
    mreq     = '0;
    mreq.acc = acc;
    mreq.sel = pnl_rs_pkg::CHUNK_LO;
    unique case (state)
      S_SQ0: begin
        mreq.clr = 1'b1;
        mreq.a   = A_W'(mag);
        mreq.b   = mag[B_W-1:0];
      end
      S_SQ1: begin
        mreq.sel = pnl_rs_pkg::CHUNK_MID;
        mreq.a   = A_W'(mag);
        mreq.b   = mag[2*B_W-1:B_W];
      end
      S_M0: begin
        mreq.clr = 1'b1;
        mreq.a   = A_W'(abs_sum);
        mreq.b   = abs_sum[B_W-1:0];
      end
      S_M1: begin
        mreq.sel = pnl_rs_pkg::CHUNK_MID;
        mreq.a   = A_W'(abs_sum);
        mreq.b   = abs_sum[2*B_W-1:B_W];
      end
      S_M2: begin
        mreq.sel = pnl_rs_pkg::CHUNK_HI;
        mreq.a   = A_W'(abs_sum);
        mreq.b   = B_W'(abs_sum[SUM_W-1:2*B_W]);
      end
      S_M3: begin
        mreq.clr = 1'b1;
        mreq.a   = A_W'(sumsq);
        mreq.b   = days;
      end
      S_M4: begin
        mreq.clr = 1'b1;
        mreq.a   = var_n;
        mreq.b   = days;
      end
      S_M5: begin
        mreq.clr = 1'b1;
        mreq.a   = A_W'(days - CNT_W'(1));
        mreq.b   = B_W'(ppy);
      end
      S_M6: begin
        mreq.clr = 1'b1;
        mreq.a   = s2;
        mreq.b   = acc[B_W-1:0];
      end
      S_M7: begin
        mreq.sel = pnl_rs_pkg::CHUNK_MID;
        mreq.a   = s2;
        mreq.b   = B_W'(kp[KP_W-1:B_W]);
      end
      default: begin
        mreq.clr = 1'b1;
      end
    endcase
  end

  always_comb begin
    sreq.pair  = (state == S_SQRT);
    sreq.bits  = nbits[QB_W-1:QB_W-2];
    sreq.rem   = r;
    sreq.trial = (state == S_SQRT) ? REM_W'({root, 2'b01}) : REM_W'(dvs);
  end

  pnl_rs_mac u_mac (
    .req (mreq),
    .sum (macc)
  );

  pnl_rs_step u_step (
    .req (sreq),
    .rsp (srsp)
  );

  assign pnl_in.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      ppy       <= pnl_rs_pkg::PPY_RESET;
      days      <= '0;
      sum       <= '0;
      sumsq     <= '0;
      peak      <= '0;
      worst_dd  <= '0;
      wins      <= '0;
      best      <= '0;
      worst     <= '0;
    end else begin
      if (cfg.valid) begin
        ppy <= cfg.data;
      end
      // S_DONE loads the result register only when it is free or draining
      if (state == S_DONE) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      acc <= macc;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            v     <= pnl_in.day_value;
            full  <= (days >= CNT_W'(pnl_rs_pkg::MAX_DAYS));
            state <= (days >= CNT_W'(pnl_rs_pkg::MAX_DAYS)) ? S_DDS : S_SQ0;
          end
        end
        S_SQ0: state <= S_SQ1;
        S_SQ1: state <= S_UPD;
        S_UPD: begin
          if (days == '0) begin
            best  <= v;
            worst <= v;
          end else begin
            if (v > best)  best  <= v;
            if (v < worst) worst <= v;
          end
          days  <= days + CNT_W'(1);
          sum   <= sum_new;
          sumsq <= sumsq + acc[SQ_W-1:0];
          if (v > PB'(0)) wins <= wins + CNT_W'(1);
          if (sum_new > peak) peak <= sum_new;
          state <= S_DDS;
        end
        S_DDS: begin
          if (peak <= SUM_W'(0)) begin
            state <= S_WRS;
          end else if ((SUM_W+4)'(diff) >= {peak, 4'b0000}) begin
            worst_dd <= pnl_rs_pkg::DD_SAT;
            state    <= S_WRS;
          end else begin
            // quotient fits 20 bits: start from the numerator without its low 20 bits
            r     <= REM_W'(diff[SUM_W-1:4]);
            nbits <= {diff[3:0], (QB_W-4)'(0)};
            dvs   <= DEN_W'(peak);
            cnt   <= STEP_W'(pnl_rs_pkg::DD_STEPS);
            state <= S_DDDIV;
          end
        end
        S_DDDIV: begin
          r     <= srsp.rem;
          quo   <= {quo[QB_W-2:0], srsp.ge};
          nbits <= nbits << 1;
          cnt   <= cnt - STEP_W'(1);
          if (last) begin
            if (dd_q > worst_dd) worst_dd <= dd_q;
            state <= S_WRS;
          end
        end
        S_WRS: begin
          if (days == '0) begin
            winr  <= '0;
            state <= S_M0;
          end else begin
            r     <= REM_W'(wins[CNT_W-1:1]);
            nbits <= {wins[0], (QB_W-1)'(0)};
            dvs   <= DEN_W'(days);
            cnt   <= STEP_W'(pnl_rs_pkg::WR_STEPS);
            state <= S_WRDIV;
          end
        end
        S_WRDIV: begin
          r     <= srsp.rem;
          quo   <= {quo[QB_W-2:0], srsp.ge};
          nbits <= nbits << 1;
          cnt   <= cnt - STEP_W'(1);
          if (last) begin
            winr  <= {quo[WR_W-2:0], srsp.ge};
            state <= S_M0;
          end
        end
        S_M0: state <= S_M1;
        S_M1: state <= S_M2;
        S_M2: state <= S_M3;
        S_M3: begin
          s2    <= acc[A_W-1:0];
          state <= S_M4;
        end
        S_M4: begin
          // zero below two days or when the variance vanishes
          if (days < CNT_W'(2) || s2 >= acc[A_W-1:0]) begin
            sharpe <= '0;
            state  <= S_DONE;
          end else begin
            state <= S_M5;
          end
        end
        S_M5: begin
          den   <= acc[DEN_W-1:0];
          state <= S_M6;
        end
        S_M6: begin
          kp    <= acc[KP_W-1:0];
          state <= S_M7;
        end
        S_M7: state <= S_M8;
        S_M8: begin
          if (DEN_W'(top) >= den) begin
            sharpe <= sum[SUM_W-1] ? pnl_rs_pkg::SH_NEG_SAT : pnl_rs_pkg::SH_POS_SAT;
            state  <= S_DONE;
          end else begin
            r     <= REM_W'(top);
            nbits <= {acc[13:0], (QB_W-14)'(0)};
            dvs   <= den;
            cnt   <= STEP_W'(pnl_rs_pkg::SH_STEPS);
            state <= S_SHDIV;
          end
        end
        S_SHDIV: begin
          quo <= {quo[QB_W-2:0], srsp.ge};
          if (last) begin
            // hand the quotient to the root: two bits per step
            nbits <= {quo[QB_W-2:0], srsp.ge};
            r     <= '0;
            root  <= '0;
            cnt   <= STEP_W'(pnl_rs_pkg::SQ_STEPS);
            state <= S_SQRT;
          end else begin
            r     <= srsp.rem;
            nbits <= nbits << 1;
            cnt   <= cnt - STEP_W'(1);
          end
        end
        S_SQRT: begin
          r     <= srsp.rem;
          root  <= root_q;
          nbits <= nbits << 2;
          cnt   <= cnt - STEP_W'(1);
          if (last) begin
            sharpe <= sum[SUM_W-1] ? SH_W'(0) - SH_W'(root_q) : SH_W'(root_q);
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || res.ready) begin
            o_days    <= days;
            o_sum     <= sum;
            o_best    <= best;
            o_worst   <= worst;
            o_winr    <= winr;
            o_dd      <= worst_dd;
            o_sharpe  <= sharpe;
            o_full    <= full;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid        = res_valid;
  assign res.day_count    = o_days;
  assign res.pnl_sum      = o_sum;
  assign res.best_day     = o_best;
  assign res.worst_day    = o_worst;
  assign res.win_frac     = o_winr;
  assign res.dd_max       = o_dd;
  assign res.sharpe       = o_sharpe;
  assign res.full_res     = o_full;

endmodule

### rtl/core/pnl_rs_checker.sv
// Port checker for the running statistics block, bound to the top level.
`include "pnl_running_statistics_assert.svh"

module pnl_rs_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   res_valid,
  input logic                                   res_ready,
  input logic [pnl_rs_pkg::CNT_W-1:0]           res_day_count,
  input logic signed [pnl_rs_pkg::PNL_BITS-1:0] res_best,
  input logic signed [pnl_rs_pkg::PNL_BITS-1:0] res_worst,
  input logic                                   res_full
);

  `PNL_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_day_count))
  `PNL_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `PNL_ASSERT_NOW(a_full_at_cap, clk, rst, res_valid && res_full, res_day_count == pnl_rs_pkg::CNT_W'(pnl_rs_pkg::MAX_DAYS))
  `PNL_ASSERT_NOW(a_best_ge_worst, clk, rst, res_valid, res_best >= res_worst)

endmodule

bind pnl_running_statistics pnl_rs_checker u_pnl_rs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pnl_in.valid),
  .in_ready      (pnl_in.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_day_count (res.day_count),
  .res_best      (res.best_day),
  .res_worst     (res.worst_day),
  .res_full      (res.full_res)
);

### tb/sv/pnl_rs_checker.sv
// Checker: predicts the running statistics for every accepted day and compares the results.
`timescale 1ns / 100ps

module pnl_rs_scoreboard (
  input  logic  clk,
  input  logic  rst,
  pnl_rs_in_if  pnl_in,
  pnl_rs_out_if res,
  pnl_rs_cfg_if cfg,
  output int    fail_count,
  output int    pending
);
  localparam int CNT_W    = pnl_rs_pkg::CNT_W;
  localparam int SUM_W    = pnl_rs_pkg::SUM_W;
  localparam int SQ_W     = pnl_rs_pkg::SQ_W;
  localparam int DD_W     = pnl_rs_pkg::DD_W;
  localparam int WR_W     = pnl_rs_pkg::WR_W;
  localparam int SH_W     = pnl_rs_pkg::SH_W;
  localparam int PPY_W    = pnl_rs_pkg::PPY_W;
  localparam int PNL_BITS = pnl_rs_pkg::PNL_BITS;
  localparam int MAX_DAYS = pnl_rs_pkg::MAX_DAYS;

  typedef struct packed {
    logic [CNT_W-1:0]           day_count;
    logic signed [SUM_W-1:0]    pnl_sum;
    logic signed [PNL_BITS-1:0] best_day;
    logic signed [PNL_BITS-1:0] worst_day;
    logic [WR_W-1:0]            win_frac;
    logic [DD_W-1:0]            dd_max;
    logic signed [SH_W-1:0]     sharpe;
    logic                       full_res;
  } figures_t;

  figures_t figures_q[$];

  logic [PPY_W-1:0]           ppy;
  logic [CNT_W-1:0]           days;
  logic signed [SUM_W-1:0]    cum;
  logic [SQ_W-1:0]            sq_sum;
  logic signed [SUM_W-1:0]    peak;
  logic [DD_W-1:0]            worst_dd;
  logic [CNT_W-1:0]           wins;
  logic signed [PNL_BITS-1:0] top_day;
  logic signed [PNL_BITS-1:0] low_day;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 46;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [SH_W-1:0] annual_sharpe();
    logic [127:0] mag, s2, nq, den, num, top, quot, scale;
    logic [63:0]  m;
    if (days < 2 || ppy == 0) return '0;
    mag = (cum < 0) ? 128'(-cum) : 128'(cum);
    s2 = mag * mag;
    nq = 128'(sq_sum) * 128'(days);
    if (s2 >= nq) return '0;
    den = (nq - s2) * 128'(days);
    scale = 128'(days - 1) * 128'(ppy);
    num = (s2 * scale) << 32;
    top = num >> 46;
    if (top >= den) begin
      m = 64'd8388608;
    end else begin
      quot = num / den;
      m = int_sqrt(quot[63:0]);
    end
    if (cum < 0) begin
      if (m > 64'd8388608) m = 64'd8388608;
      return SH_W'(64'd0 - m);
    end
    if (m > 64'd8388607) m = 64'd8388607;
    return SH_W'(m);
  endfunction

  // Update the statistics with one day and return the figures to report.
  function automatic figures_t record_day(input logic signed [PNL_BITS-1:0] v);
    figures_t f;
    logic [SUM_W-1:0] diff;
    logic [63:0]      dd;
    f.full_res = 1'b0;
    if (days >= MAX_DAYS) begin
      f.full_res = 1'b1;
    end else begin
      if (days == 0) begin
        top_day = v;
        low_day = v;
      end else begin
        if (v > top_day) top_day = v;
        if (v < low_day) low_day = v;
      end
      days = days + 1;
      cum = cum + SUM_W'(v);
      sq_sum = sq_sum + SQ_W'(64'(v) * 64'(v));
      if (v > 0) wins = wins + 1;
      if (cum > peak) peak = cum;
      if (peak > 0) begin
        diff = peak - cum;
        dd = ({26'd0, diff} << 16) / 64'(peak);
        if (dd > 64'(pnl_rs_pkg::DD_SAT)) dd = 64'(pnl_rs_pkg::DD_SAT);
        if (dd > 64'(worst_dd)) worst_dd = DD_W'(dd);
      end
    end
    f.day_count = days;
    f.pnl_sum = cum;
    f.best_day = top_day;
    f.worst_day = low_day;
    f.win_frac = (days == 0) ? '0 : WR_W'((32'(wins) << 16) / 32'(days));
    f.dd_max = worst_dd;
    f.sharpe = annual_sharpe();
    return f;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch %s: expected %0d got %0d", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    figures_t e;
    if (rst) begin
      ppy <= pnl_rs_pkg::PPY_RESET;
      days = 0;
      cum = 0;
      sq_sum = 0;
      peak = 0;
      worst_dd = 0;
      wins = 0;
      top_day = 0;
      low_day = 0;
      fail_count = 0;
      figures_q.delete();
      pending <= 0;
    end else begin
      if (cfg.valid && cfg.ready) ppy <= cfg.data;
      if (pnl_in.valid && pnl_in.ready)
        figures_q.insert(figures_q.size(), record_day(pnl_in.day_value));
      if (res.valid && res.ready) begin
        if (figures_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result with no expected figures");
        end else begin
          e = figures_q.pop_front();
          check_field("day_count", 64'(e.day_count), 64'(res.day_count));
          check_field("pnl_sum", 64'(e.pnl_sum), 64'(res.pnl_sum));
          check_field("best_day", 64'(e.best_day), 64'(res.best_day));
          check_field("worst_day", 64'(e.worst_day), 64'(res.worst_day));
          check_field("win_frac", 64'(e.win_frac), 64'(res.win_frac));
          check_field("dd_max", 64'(e.dd_max), 64'(res.dd_max));
          check_field("sharpe", 64'(e.sharpe), 64'(res.sharpe));
          check_field("full_res", 64'(e.full_res), 64'(res.full_res));
        end
      end
      pending <= figures_q.size();
    end
  end

endmodule

### tb/sv/testbench.sv
// Testbench top: drives days and settings into the running statistics block and gives the verdict.
`timescale 1ns / 100ps

module testbench;
  localparam int PNL_BITS         = pnl_rs_pkg::PNL_BITS;
  localparam int PPY_W            = pnl_rs_pkg::PPY_W;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int HOLD_CYCLES      = 800;
  localparam int HOLD_AT          = 150;
  localparam int ITEMS_PER_PERIOD = 95;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   days_sent = 0;
  int   stall_cycles = 0;
  bit   calm;

  pnl_rs_in_if  pnl_in ();
  pnl_rs_out_if res ();
  pnl_rs_cfg_if cfg ();

  pnl_running_statistics u_top (.clk(clk), .rst(rst), .pnl_in(pnl_in), .res(res), .cfg(cfg));

  pnl_rs_scoreboard u_checker (
    .clk(clk), .rst(rst), .pnl_in(pnl_in), .res(res), .cfg(cfg),
    .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  assign calm = (days_sent >= 230 && days_sent < 290);

  // Receiver: random stalls, one long hold-off so the block backs up.
  always @(posedge clk) begin
    int hold_left;
    if (rst) begin
      res.ready <= 1'b0;
      hold_left = 0;
    end else if (days_sent == HOLD_AT && hold_left == 0 && stall_cycles >= 0) begin
      hold_left = HOLD_CYCLES;
      stall_cycles = -1;
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= (!calm && $urandom_range(99) < 27) ? 1'b0 : 1'b1;
    end
  end

  // Watchdog: count cycles with nothing accepted.
  always @(posedge clk) begin
    int idle_run;
    if (rst || (pnl_in.valid && pnl_in.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_day(input logic signed [PNL_BITS-1:0] v);
    if (!calm && $urandom_range(99) < 27) begin
      pnl_in.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pnl_in.valid <= 1'b1;
    pnl_in.day_value <= v;
    @(posedge clk);
    while (!pnl_in.ready) @(posedge clk);
    days_sent++;
  endtask

  task automatic write_periods(input logic [PPY_W-1:0] v);
    pnl_in.valid <= 1'b0;
    // let the result of every accepted item be checked first
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Emit a burst of days of one flavor: trend, full range, extremes or small values.
  task automatic send_burst();
    int kind, len, base, jitter;
    logic signed [PNL_BITS-1:0] v;
    kind = $urandom_range(99);
    len = $urandom_range(5, 40);
    base = $signed($urandom_range(2000000)) - 1000000;
    jitter = $urandom_range(1, 5000);
    repeat (len) begin
      if (kind < 45) v = PNL_BITS'(base + $signed($urandom_range(2 * jitter)) - jitter);
      else if (kind < 70) v = PNL_BITS'($urandom);
      else if (kind < 85) begin
        case ($urandom_range(4))
          0: v = {1'b1, {(PNL_BITS-1){1'b0}}};
          1: v = {1'b0, {(PNL_BITS-1){1'b1}}};
          2: v = '0;
          3: v = PNL_BITS'(1);
          default: v = PNL_BITS'(-1);
        endcase
      end else v = PNL_BITS'($signed($urandom_range(200)) - 100);
      send_day(v);
    end
  endtask

  initial begin
    logic [PPY_W-1:0] periods[5];
    periods = '{9'd366, 9'd1, 9'd511, 9'd0, 9'd252};
    pnl_in.valid = 1'b0;
    pnl_in.day_value = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: negative start, zero variance, saturated drawdown, extremes.
    send_day(PNL_BITS'(-5));
    send_day(PNL_BITS'(-5));
    send_day(PNL_BITS'(7));
    send_day(PNL_BITS'(20));
    send_day({1'b1, {(PNL_BITS-1){1'b0}}});
    send_day({1'b0, {(PNL_BITS-1){1'b1}}});
    send_day(PNL_BITS'(0));
    send_day(PNL_BITS'(1));
    send_day(PNL_BITS'(-1));
    send_day(PNL_BITS'(1000));
    send_day(PNL_BITS'(1001));
    send_day(PNL_BITS'(1000));

    foreach (periods[p]) begin
      write_periods(periods[p]);
      while (days_sent < 12 + (p + 1) * ITEMS_PER_PERIOD) send_burst();
    end
    pnl_in.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
